// File: rtl/brd_pkg.sv
// Shared types, constants and lookup tables for the band relay driver.
// Used by brd_keys, brd_map and the top level; depends on nothing else.
package brd_pkg;

  localparam int unsigned KeyCount = 3;

  localparam logic [7:0]  PressPattern   = 8'h80;
  localparam logic [7:0]  ReleasePattern = 8'h7F;
  localparam logic [31:0] CtrlWordReset  = 32'h0210_0000;

  // Item opcodes.
  localparam logic OpTick    = 1'b0;
  localparam logic OpCommand = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  key_levels;
    logic [31:0] control_word;
    logic [7:0]  band_byte;
  } brd_item_t;

  typedef struct packed {
    logic [15:0] shift_word_first;
    logic [15:0] shift_word_second;
    logic [15:0] shift_word_third;
    logic [15:0] shift_word_fourth;
    logic [15:0] shift_word_fifth;
    logic [15:0] port_a_bits;
    logic [6:0]  port_b_bits;
  } brd_result_t;

  // Status from the key debouncer to the top level.
  typedef struct packed {
    logic [KeyCount-1:0] pressed;
    logic                hit;
  } brd_key_stat_t;

  // Band code to BCD value; codes 12 to 15 read as zero.
  function automatic logic [3:0] bcd_map(input logic [3:0] code);
    logic [3:0] v;
    case (code)
      4'd0:    v = 4'd15;
      4'd1:    v = 4'd1;
      4'd2:    v = 4'd2;
      4'd3:    v = 4'd0;
      4'd4:    v = 4'd3;
      4'd5:    v = 4'd4;
      4'd6:    v = 4'd5;
      4'd7:    v = 4'd6;
      4'd8:    v = 4'd7;
      4'd9:    v = 4'd8;
      4'd10:   v = 4'd9;
      4'd11:   v = 4'd10;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // Antenna selection code to antenna group.
  function automatic logic [1:0] antenna_map(input logic [3:0] sel);
    logic [1:0] v;
    if (sel inside {[4'd0:4'd3]}) begin
      v = 2'd0;
    end else if (sel inside {[4'd4:4'd7], 4'd15}) begin
      v = 2'd1;
    end else begin
      v = 2'd2;
    end
    return v;
  endfunction

  // Single set bit at pos; nothing when pos falls off the 32-bit word.
  function automatic logic [31:0] one_hot(input logic [5:0] pos);
    logic [31:0] v;
    v = '0;
    if (pos < 6'd32) begin
      v[pos[4:0]] = 1'b1;
    end
    return v;
  endfunction

endpackage

// File: rtl/brd_keys.sv
// Key debouncer: three 8-bit level histories and their pressed latches.
// Depends on brd_pkg.
module brd_keys (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  brd_pkg::brd_item_t    item,
  output brd_pkg::brd_key_stat_t stat
);
  import brd_pkg::*;

  logic [7:0]          history      [KeyCount];
  logic [7:0]          history_next [KeyCount];
  logic [KeyCount-1:0] pressed;
  logic [KeyCount-1:0] pressed_next;
  logic                tick;
  logic                hit;

  assign tick = accept && (item.opcode == OpTick);

  always_comb begin
    hit          = 1'b0;
    pressed_next = pressed;
    for (int i = 0; i < KeyCount; i++) begin
      history_next[i] = {history[i][6:0], item.key_levels[i]};
      if (history_next[i] == PressPattern) begin
        pressed_next[i] = 1'b1;
        hit             = 1'b1;
      end else if (history_next[i] == ReleasePattern) begin
        pressed_next[i] = 1'b0;
        hit             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyCount; i++) begin
        history[i] <= '0;
      end
      pressed <= '0;
    end else if (tick) begin
      for (int i = 0; i < KeyCount; i++) begin
        history[i] <= history_next[i];
      end
      pressed <= pressed_next;
    end
  end

  assign stat.pressed = pressed;
  assign stat.hit     = tick && hit;

endmodule

// File: rtl/brd_map.sv
// Maps the held command and key latches to the five shift words and port words.
// Purely combinational; depends on brd_pkg.
module brd_map (
  input  logic [31:0]                  ctrl,
  input  logic [7:0]                   band,
  input  logic [brd_pkg::KeyCount-1:0] pressed,
  output brd_pkg::brd_result_t         result
);
  import brd_pkg::*;

  logic        tx;
  logic        ptt;
  logic [3:0]  sel_ant;
  logic [3:0]  code0_raw;
  logic [3:0]  code0;
  logic [3:0]  code1;
  logic [3:0]  code2;
  logic [2:0]  lpf;
  logic [31:0] d0;
  logic [31:0] d1;
  logic [31:0] d2;
  logic [31:0] b0;
  logic [31:0] b1;
  logic [31:0] b2;
  logic [31:0] b3;
  logic [31:0] b4;
  logic [31:0] b5;
  logic [31:0] b6;

  assign tx        = ctrl[0];
  assign ptt       = ctrl[1];
  assign sel_ant   = {ctrl[10:9], ctrl[1:0]};
  assign code0_raw = tx ? band[7:4] : band[3:0];

  always_comb begin
    if (code0_raw == 4'd2) begin
      lpf = 3'd1;
    end else if (code0_raw inside {4'd3, 4'd4}) begin
      lpf = 3'd2;
    end else if (code0_raw inside {4'd5, 4'd6}) begin
      lpf = 3'd3;
    end else if (code0_raw inside {4'd7, 4'd8}) begin
      lpf = 3'd4;
    end else if (code0_raw inside {4'd9, 4'd10}) begin
      lpf = 3'd5;
    end else if (code0_raw inside {4'd11, 4'd0}) begin
      lpf = 3'd6;
    end else begin
      lpf = 3'd0;
    end
  end

  // A pressed key forces its band code to zero after the filter choice.
  assign code0 = pressed[0] ? 4'd0 : code0_raw;
  assign code1 = pressed[1] ? 4'd0 : band[3:0];
  assign code2 = pressed[2] ? 4'd0 : band[7:4];

  always_comb begin
    d0 = {bcd_map(code1), 28'd0} | {2'd0, ctrl[31:2]};

    d1 = {28'd0, bcd_map(code2)}
       | one_hot({2'd0, code0} + 6'd4)
       | one_hot({2'd0, code1} + 6'd16)
       | one_hot({2'd0, code2} + 6'd28);

    d2 = ((code2 > 4'd3) ? one_hot({2'd0, code2} - 6'd4) : 32'd0)
       | one_hot({3'd0, lpf} + 6'd8);
    d2[15]    = d2[15] | tx;
    d2[16]    = d2[16] | (ptt && !tx);
    d2[17]    = d2[17] | (ptt && tx);
    d2[18]    = d2[18] | ptt;
    d2[19]    = d2[19] | (ctrl[24:20] == 5'd0);
    d2[20]    = d2[20] | (ctrl[29:25] == 5'd0);
    d2[22:21] = d2[22:21] | antenna_map(sel_ant);

    b0 = ((d1 >> 6) & 32'h0400) | ((d1 >> 8) & 32'h0200) | ((d1 >> 10) & 32'h0100)
       | ((d1 >> 15) & 32'h00F0) | ((d1 >> 16) & 32'h0800) | ((d1 >> 20) & 32'h0008)
       | ((d1 >> 22) & 32'h0004) | ((d1 >> 24) & 32'h0002) | ((d1 >> 26) & 32'h0001)
       | ((d2 << 4) & 32'hF000);
    b1 = ((d0 << 3) & 32'h03F8) | ((d0 << 1) & 32'h8000) | ((d0 >> 2) & 32'h0C00)
       | ((d2 << 9) & 32'h7000) | ((d2 >> 12) & 32'h0007);
    b2 = ((d0 << 5) & 32'h3000) | (d0 & 32'h0E00) | ((d0 >> 1) & 32'hC000)
       | ((d1 >> 20) & 32'h0100) | ((d1 >> 23) & 32'h00C0) | ((d1 >> 29) & 32'h0004)
       | ((d2 << 3) & 32'h0008) | (d2 & 32'h0002) | ((d2 >> 1) & 32'h0020)
       | ((d2 >> 2) & 32'h0001) | ((d2 >> 3) & 32'h0010);
    b3 = ((d0 >> 15) & 32'h0004) | ((d0 >> 24) & 32'h00F0) | ((d1 << 8) & 32'h0F00)
       | ((d1 << 2) & 32'hF000) | ((d2 >> 12) & 32'h0008) | ((d2 >> 16) & 32'h0003);
    b4 = ((d1 << 2) & 32'h0080) | (d1 & 32'h0010) | ((d1 >> 4) & 32'h000C)
       | ((d1 >> 7) & 32'h0002) | ((d1 >> 8) & 32'h0040) | ((d1 >> 9) & 32'h0001)
       | ((d1 >> 10) & 32'h0020) | ((d2 >> 10) & 32'h1F00);
    b5 = ((d0 >> 8) & 32'h8000) | ((d0 >> 15) & 32'h00F8);
    b6 = (d0 >> 21) & 32'h0078;
  end

  assign result.shift_word_first  = b4[15:0];
  assign result.shift_word_second = b3[15:0];
  assign result.shift_word_third  = b2[15:0];
  assign result.shift_word_fourth = b1[15:0];
  assign result.shift_word_fifth  = b0[15:0];
  assign result.port_a_bits       = b5[15:0];
  assign result.port_b_bits       = b6[6:0];

endmodule

// File: rtl/band_relay_driver_with_key_debounce.sv
// Top level of the band relay driver with key debounce.
// Instantiates brd_keys and brd_map; depends on brd_pkg.
//
// Usage:
// Items arrive on the cmd channel (cmd_valid, cmd_stall, cmd) and results
// leave on the res channel (res_valid, res_stall, res). A transaction
// completes at a rising clock edge where valid is high and stall is low.
// An item is either a sample tick carrying three raw key levels or a
// command carrying a control word and a band byte. A command always
// produces one result. A tick produces one only when some key history hits
// the press or release pattern; otherwise it just updates the histories.
// The accepting edge updates the held command and key state and marks a
// result as pending, and a later edge at which the result register can
// advance loads the mapped relay words into it. One item can be accepted
// every cycle while cmd_stall is low, so the sustained rate is one item per
// clock, set by the single mapping stage between the state and result registers.
// When the receiver stalls, the result register holds its transaction and
// a pending result waits in front of it; cmd_stall rises only while both
// are occupied. Reset clears the histories and latches, loads the control
// word reset value, clears the band byte and empties both stages.
module band_relay_driver_with_key_debounce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  brd_pkg::brd_item_t   cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output brd_pkg::brd_result_t res
);
  import brd_pkg::*;

  logic          accept;
  logic          advance;
  logic          pending;
  logic [31:0]   ctrl;
  logic [7:0]    band;
  brd_key_stat_t key_stat;
  brd_result_t   mapped;

  // The result register moves when it is empty or its transaction is taken.
  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = pending && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  brd_keys u_keys (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (cmd),
    .stat   (key_stat)
  );

  // Held command words; a command replaces both.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= CtrlWordReset;
      band <= '0;
    end else if (accept && cmd.opcode == OpCommand) begin
      ctrl <= cmd.control_word;
      band <= cmd.band_byte;
    end
  end

  // The pending flag says the held state must be mapped into a result.
  // While it is set and the output is blocked, no new item is taken, so the
  // state it refers to stays frozen.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= (cmd.opcode == OpCommand) || key_stat.hit;
    end else if (advance) begin
      pending <= 1'b0;
    end
  end

  brd_map u_map (
    .ctrl    (ctrl),
    .band    (band),
    .pressed (key_stat.pressed),
    .result  (mapped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pending) begin
      res <= mapped;
    end
  end

  // An accepted command always leaves a result pending.
  assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == OpCommand |=> pending)
    else $error("command did not leave a pending result");

  // The input is only held off while a result waits behind a blocked output.
  assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> pending && res_valid && res_stall)
    else $error("input stalled without a blocked pending result");

  // A pending result reaches the output register on the next free edge.
  assert property (@(posedge clk) disable iff (rst)
    pending && advance |=> res_valid)
    else $error("pending result was dropped");

  // Key latches change only on an accepted tick.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(key_stat.pressed) |-> $past(accept && cmd.opcode == OpTick))
    else $error("key latch changed without a tick");

endmodule

// File: tb/brd_tb_pkg.sv
`timescale 1ns / 100ps
// Relay word tracker for the band relay driver testbench: it keeps its own
// copy of the key and command state and predicts every relay word set.
// Depends on brd_pkg for the item and result types and the latch patterns.
package brd_tb_pkg;
  import brd_pkg::*;

  // Band code to BCD digit; codes 12 to 15 carry no digit.
  localparam logic [3:0] BcdValue [16] = '{
    4'd15, 4'd1, 4'd2, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6,
    4'd7, 4'd8, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0
  };
  // Antenna selection to antenna group.
  localparam logic [1:0] AntennaGroup [16] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  class relay_tracker;
    logic [7:0]  history [KeyCount];
    logic        pressed [KeyCount];
    logic [31:0] ctrl;
    logic [7:0]  band;
    brd_result_t relay_words_due [$];
    int          errors;

    function new();
      for (int k = 0; k < KeyCount; k++) begin
        history[k] = 8'h00;
        pressed[k] = 1'b0;
      end
      ctrl   = CtrlWordReset;
      band   = 8'h00;
      errors = 0;
    endfunction

    function int unsigned pending();
      return relay_words_due.size();
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // A set bit at pos, or nothing once pos leaves the 32-bit word.
    function logic [31:0] bit_at(input int pos);
      return (pos >= 0 && pos < 32) ? (32'd1 << pos) : 32'd0;
    endfunction

    function brd_result_t map_relay_words();
      logic [31:0] w, d0, d1, d2, b0, b1, b2, b3, b4, b5, b6;
      logic        tx, ptt;
      logic [3:0]  sel_ant, code0, code1, code2, lpf;
      logic [4:0]  att0, att1;
      brd_result_t r;
      w       = ctrl;
      tx      = w[0];
      ptt     = w[1];
      sel_ant = {w[10:9], w[1:0]};
      att0    = w[24:20];
      att1    = w[29:25];
      code2   = band[7:4];
      code1   = band[3:0];
      code0   = tx ? code2 : code1;
      // The filter follows the selected band before any key overrides it.
      case (code0)
        4'd2:        lpf = 4'd1;
        4'd3, 4'd4:  lpf = 4'd2;
        4'd5, 4'd6:  lpf = 4'd3;
        4'd7, 4'd8:  lpf = 4'd4;
        4'd9, 4'd10: lpf = 4'd5;
        4'd11, 4'd0: lpf = 4'd6;
        default:     lpf = 4'd0;
      endcase
      if (pressed[2]) code2 = 4'd0;
      if (pressed[1]) code1 = 4'd0;
      if (pressed[0]) code0 = 4'd0;

      d0 = (32'(BcdValue[code1]) << 28) | (w >> 2);
      d1 = 32'(BcdValue[code2]) | bit_at(int'(code0) + 4) | bit_at(int'(code1) + 16)
         | bit_at(int'(code2) + 28);
      d2 = (code2 > 4'd3) ? bit_at(int'(code2) - 4) : 32'd0;
      d2 |= bit_at(int'(lpf) + 8);
      d2 |= 32'(tx) << 15;
      d2 |= 32'(ptt && !tx) << 16;
      d2 |= 32'(ptt && tx) << 17;
      d2 |= 32'(ptt) << 18;
      d2 |= 32'(att0 == 5'd0) << 19;
      d2 |= 32'(att1 == 5'd0) << 20;
      d2 |= 32'(AntennaGroup[sel_ant]) << 21;

      b0 = ((d1 >> 6) & 32'h0400) | ((d1 >> 8) & 32'h0200) | ((d1 >> 10) & 32'h0100)
         | ((d1 >> 15) & 32'h00F0) | ((d1 >> 16) & 32'h0800) | ((d1 >> 20) & 32'h0008)
         | ((d1 >> 22) & 32'h0004) | ((d1 >> 24) & 32'h0002) | ((d1 >> 26) & 32'h0001)
         | ((d2 << 4) & 32'hF000);
      b1 = ((d0 << 3) & 32'h03F8) | ((d0 << 1) & 32'h8000) | ((d0 >> 2) & 32'h0C00)
         | ((d2 << 9) & 32'h7000) | ((d2 >> 12) & 32'h0007);
      b2 = ((d0 << 5) & 32'h3000) | (d0 & 32'h0E00) | ((d0 >> 1) & 32'hC000)
         | ((d1 >> 20) & 32'h0100) | ((d1 >> 23) & 32'h00C0) | ((d1 >> 29) & 32'h0004)
         | ((d2 << 3) & 32'h0008) | (d2 & 32'h0002) | ((d2 >> 1) & 32'h0020)
         | ((d2 >> 2) & 32'h0001) | ((d2 >> 3) & 32'h0010);
      b3 = ((d0 >> 15) & 32'h0004) | ((d0 >> 24) & 32'h00F0) | ((d1 << 8) & 32'h0F00)
         | ((d1 << 2) & 32'hF000) | ((d2 >> 12) & 32'h0008) | ((d2 >> 16) & 32'h0003);
      b4 = ((d1 << 2) & 32'h0080) | (d1 & 32'h0010) | ((d1 >> 4) & 32'h000C)
         | ((d1 >> 7) & 32'h0002) | ((d1 >> 8) & 32'h0040) | ((d1 >> 9) & 32'h0001)
         | ((d1 >> 10) & 32'h0020) | ((d2 >> 10) & 32'h1F00);
      b5 = ((d0 >> 8) & 32'h8000) | ((d0 >> 15) & 32'h00F8);
      b6 = (d0 >> 21) & 32'h0078;

      r.shift_word_first  = b4[15:0];
      r.shift_word_second = b3[15:0];
      r.shift_word_third  = b2[15:0];
      r.shift_word_fourth = b1[15:0];
      r.shift_word_fifth  = b0[15:0];
      r.port_a_bits       = b5[15:0];
      r.port_b_bits       = b6[6:0];
      return r;
    endfunction

    // Called for every accepted input transaction.
    function void note_accepted_item(input brd_item_t it);
      logic fire;
      fire = 1'b0;
      if (it.opcode == OpCommand) begin
        ctrl = it.control_word;
        band = it.band_byte;
        fire = 1'b1;
      end else begin
        for (int k = 0; k < KeyCount; k++) begin
          history[k] = {history[k][6:0], it.key_levels[k]};
          if (history[k] == PressPattern) begin
            pressed[k] = 1'b1;
            fire = 1'b1;
          end else if (history[k] == ReleasePattern) begin
            pressed[k] = 1'b0;
            fire = 1'b1;
          end
        end
      end
      if (fire) relay_words_due.push_back(map_relay_words());
    endfunction

    task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
        report($sformatf("%s got 0x%04h expected 0x%04h", name, got, want));
      end
    endtask

    // Called for every accepted result transaction.
    task check_relay_words(input brd_result_t got);
      brd_result_t want;
      if (relay_words_due.size() == 0) begin
        report($sformatf("unexpected result 0x%h", got));
      end else begin
        want = relay_words_due.pop_front();
        compare_field("shift_word_first", got.shift_word_first, want.shift_word_first);
        compare_field("shift_word_second", got.shift_word_second, want.shift_word_second);
        compare_field("shift_word_third", got.shift_word_third, want.shift_word_third);
        compare_field("shift_word_fourth", got.shift_word_fourth, want.shift_word_fourth);
        compare_field("shift_word_fifth", got.shift_word_fifth, want.shift_word_fifth);
        compare_field("port_a_bits", got.port_a_bits, want.port_a_bits);
        compare_field("port_b_bits", 16'(got.port_b_bits), 16'(want.port_b_bits));
      end
    endtask
  endclass

endpackage

// File: tb/tb_band_relay_driver_with_key_debounce.sv
`timescale 1ns / 100ps
// Top of the band relay driver testbench: clock, reset, item driver, result
// monitor with random stalls, and a watchdog. Depends on brd_pkg and brd_tb_pkg.
module tb_band_relay_driver_with_key_debounce;
  import brd_pkg::*;
  import brd_tb_pkg::*;

  // The watchdog ends the run after this many cycles without any transaction.
  localparam int IdleLimit   = 3000;
  // Length of the single long receiver hold-off.
  localparam int HoldCycles  = 200;
  localparam int RandomItems = 800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  brd_item_t   cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  brd_result_t res;

  relay_tracker tracker;

  // Shared between the driver and the monitor: quiet turns idling off on
  // both sides, hold_request asks the monitor for the long hold-off.
  logic quiet = 1'b0;
  logic hold_request = 1'b0;

  // Per-key level plans. A plan is shifted out from its top bit, one bit
  // per tick, so 8'h80 walks a key into the press pattern and 8'h7F into
  // the release pattern.
  logic [7:0] key_plan [KeyCount];
  int         plan_left [KeyCount];

  band_relay_driver_with_key_debounce uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic brd_item_t make_command(input logic [31:0] ctrl, input logic [7:0] band);
    brd_item_t it;
    it              = '0;
    it.opcode       = OpCommand;
    it.control_word = ctrl;
    it.band_byte    = band;
    // The unused key field still toggles so that every input bit moves.
    it.key_levels   = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic brd_item_t make_tick(input logic [2:0] levels);
    brd_item_t it;
    it              = '0;
    it.opcode       = OpTick;
    it.key_levels   = levels;
    // Command fields are ignored on a tick; random junk checks that.
    it.control_word = $urandom;
    it.band_byte    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Offers one item and returns at the edge where it is accepted. Valid
  // stays high afterwards so back-to-back items need no re-raise; an
  // optional idle gap lowers it first.
  task automatic send_item(input brd_item_t it);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd       <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    tracker.note_accepted_item(it);
  endtask

  // Builds the key levels of one random tick. Most of the time each key is
  // walking through a clean press or release sequence; the rest is short
  // random noise, and now and then a bit is flipped to break a sequence.
  task automatic next_key_levels(output logic [2:0] levels);
    int r;
    for (int k = 0; k < KeyCount; k++) begin
      if (plan_left[k] == 0) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          key_plan[k]  = PressPattern;
          plan_left[k] = 8;
        end else if (r < 8) begin
          key_plan[k]  = ReleasePattern;
          plan_left[k] = 8;
        end else begin
          key_plan[k]  = 8'($urandom);
          plan_left[k] = $urandom_range(1, 4);
        end
      end
      levels[k] = key_plan[k][7];
      if ($urandom_range(0, 99) < 4) levels[k] = ~levels[k];
      key_plan[k]  = {key_plan[k][6:0], 1'b0};
      plan_left[k] = plan_left[k] - 1;
    end
  endtask

  // Result monitor. Each accepted result transaction is checked against the
  // oldest prediction, then the stall for the next cycle is chosen: the long
  // hold-off when asked for, otherwise random stalls about 8% of the time.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) tracker.check_relay_words(res);
      if (hold > 0) begin
        hold = hold - 1;
        res_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold = HoldCycles - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !quiet && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // Watchdog: counts consecutive cycles in which neither channel completes
  // a transaction. Reaching the limit means the block has hung.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
    end
    $display("Verification failed");
    $finish;
  end

  // Main stimulus: a directed opening, then random items, then drain.
  initial begin
    logic [31:0] ctrl;
    logic [2:0]  levels;
    tracker = new();
    for (int k = 0; k < KeyCount; k++) begin
      key_plan[k]  = 8'h00;
      plan_left[k] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the command fields: all clear (both attenuators zero,
    // band code zero everywhere) and all set (codes 15 in both nibbles).
    send_item(make_command(32'h0000_0000, 8'h00));
    send_item(make_command(32'hFFFF_FFFF, 8'hFF));

    // Band code sweep: the low nibble walks 0..7 and the high nibble 8..15,
    // so the codes without a BCD digit and the one-hot bits that fall off
    // the top of the word both show up. TX alternates so that either nibble
    // selects the filter, and each command zeroes one attenuator, the two in turn.
    for (int i = 0; i < 8; i++) begin
      ctrl = $urandom;
      ctrl[0] = i[0];
      ctrl[1] = i[1];
      if (i[0]) ctrl[24:20] = 5'd0;
      else ctrl[29:25] = 5'd0;
      send_item(make_command(ctrl, {4'(i + 8), 4'(i)}));
    end

    // All three keys go through the press pattern together, then a command
    // sees the band codes forced by the pressed keys.
    send_item(make_tick(3'b111));
    repeat (7) send_item(make_tick(3'b000));
    send_item(make_command(32'h0000_0601, 8'h5A));

    // Random part. A quiet window removes idling on both sides, and later
    // the receiver holds off long enough for the block to fill up and
    // stall its input while items keep coming.
    for (int n = 0; n < RandomItems; n++) begin
      quiet = (n >= 250 && n < 400);
      if (n == 550) hold_request = 1'b1;
      if ($urandom_range(0, 99) < 20) begin
        ctrl = $urandom;
        if ($urandom_range(0, 3) == 0) ctrl[24:20] = 5'd0;
        if ($urandom_range(0, 3) == 0) ctrl[29:25] = 5'd0;
        send_item(make_command(ctrl, 8'($urandom_range(0, 255))));
      end else begin
        next_key_levels(levels);
        send_item(make_tick(levels));
      end
    end
    quiet = 1'b0;
    cmd_valid <= 1'b0;

    // Drain, then give the two-stage pipeline time to show any extra result.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: band_relay_driver_with_key_debounce.f
rtl/brd_pkg.sv
rtl/brd_keys.sv
rtl/brd_map.sv
rtl/band_relay_driver_with_key_debounce.sv
tb/brd_tb_pkg.sv
tb/tb_band_relay_driver_with_key_debounce.sv
